/* rtl/core/qtgu_pkg.sv */
package qtgu_pkg;

  localparam int NUM_STATES  = 16;
  localparam int MAX_ACTIONS = 8;
  localparam int ST_W   = $clog2(NUM_STATES);
  localparam int SLOT_W = $clog2(MAX_ACTIONS);
  localparam int CNT_W  = $clog2(MAX_ACTIONS + 1);
  localparam int ENT_W  = ST_W + SLOT_W;
  localparam int ENTRIES = NUM_STATES * MAX_ACTIONS;

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_CHOSEN = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ALPHA   = 2'd0;
  localparam logic [1:0] CFG_GAMMA   = 2'd1;
  localparam logic [1:0] CFG_HOME    = 2'd2;
  localparam logic [1:0] CFG_PENALTY = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;      // capture input transaction fields
    logic tbl_write;    // write loaded entry
    logic rd_pend;      // read pending entry quality/target
    logic cap_pend;     // capture pending q and target
    logic scan_init;    // reset argmax accumulators
    logic scan_rd;      // issue read for scan slot
    logic scan_acc;     // accumulate scan read data
    logic scan_tgt;     // scan over target state (else walk state)
    logic mul1;         // gamma*maxq stage
    logic mul2;         // alpha*inner stage
    logic wr_q;         // write back new quality
    logic emit_upd;     // emit kind 0
    logic emit_err_home;// emit kind 2 at home
    logic emit_err_cur; // emit kind 2 at current state
    logic emit_choice;  // emit kind 1 and move walk
    logic go_home;      // walk returns home
    logic use_penalty;  // reward is interrupt penalty
    logic last;         // result is final
  } qtgu_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       load_ok;
    logic       away;       // walk not at home
    logic       pend_valid;
    logic       scan_done;  // all slots issued
    logic       scan_empty; // state has no actions
  } qtgu_sts_t;

endpackage

/* rtl/core/qtgu_ram.sv */
module qtgu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/qtgu_ctrl.sv */
module qtgu_ctrl import qtgu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  qtgu_sts_t sts,
  output qtgu_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_PRD    = 4'd2;
  localparam logic [3:0] S_PCAP   = 4'd3;
  localparam logic [3:0] S_TSCAN  = 4'd4;
  localparam logic [3:0] S_TWAIT  = 4'd5;
  localparam logic [3:0] S_MUL1   = 4'd6;
  localparam logic [3:0] S_MUL2   = 4'd7;
  localparam logic [3:0] S_WB     = 4'd8;
  localparam logic [3:0] S_CSCAN  = 4'd9;
  localparam logic [3:0] S_CWAIT  = 4'd10;
  localparam logic [3:0] S_CEMIT  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       is_start_r, is_start_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      is_start_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      is_start_r <= is_start_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // sequencing
  always_comb begin
    state_nxt    = state_r;
    is_start_nxt = is_start_r;
    cmd          = '0;
    cmd.use_penalty = is_start_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        is_start_nxt = (sts.op == OP_START);
        cmd.use_penalty = (sts.op == OP_START);
        case (sts.op)
          OP_LOAD: begin
            cmd.tbl_write = sts.load_ok;
            state_nxt     = S_IDLE;
          end
          OP_START: begin
            if (sts.away) begin
              state_nxt = S_PRD;
              if (!sts.pend_valid) begin
                cmd.emit_err_home = 1'b1;
                cmd.go_home       = 1'b1;
                state_nxt         = S_CSCAN;
                cmd.scan_init     = 1'b1;
              end
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_CSCAN;
            end
          end
          OP_STOP: begin
            if (sts.pend_valid) begin
              state_nxt = S_PRD;
            end else begin
              cmd.emit_err_home = 1'b1;
              cmd.go_home       = 1'b1;
              cmd.last          = 1'b1;
              state_nxt         = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_PRD: begin
        cmd.rd_pend = 1'b1;
        state_nxt   = S_PCAP;
      end
      S_PCAP: begin
        cmd.cap_pend  = 1'b1;
        cmd.scan_init = 1'b1;
        state_nxt     = S_TSCAN;
      end
      S_TSCAN: begin
        cmd.scan_tgt = 1'b1;
        cmd.scan_rd  = !sts.scan_done;
        if (sts.scan_done) begin
          state_nxt = S_TWAIT;
        end
      end
      S_TWAIT: begin
        cmd.scan_tgt = 1'b1;
        cmd.scan_acc = 1'b1;
        state_nxt    = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        cmd.wr_q     = 1'b1;
        cmd.emit_upd = 1'b1;
        cmd.go_home  = 1'b1;
        if (is_start_r) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_CSCAN;
        end else begin
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CSCAN: begin
        cmd.scan_rd = !sts.scan_done;
        if (sts.scan_done) begin
          state_nxt = S_CWAIT;
        end
      end
      S_CWAIT: begin
        cmd.scan_acc = 1'b1;
        cmd.rd_pend  = 1'b1;
        state_nxt    = S_CEMIT;
      end
      S_CEMIT: begin
        cmd.last = 1'b1;
        if (sts.scan_empty) begin
          cmd.emit_err_cur = 1'b1;
        end else begin
          cmd.emit_choice = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/qtgu_dp.sv */
module qtgu_dp import qtgu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  qtgu_cmd_t         cmd,
  output qtgu_sts_t         sts,
  input  logic [1:0]        in_op,
  input  logic [3:0]        in_state_index,
  input  logic [2:0]        in_action_slot,
  input  logic [3:0]        in_target_state,
  input  logic [3:0]        in_action_total,
  input  logic signed [15:0] in_value,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              out_strobe,
  output logic [1:0]        out_kind,
  output logic [3:0]        out_now_state,
  output logic [2:0]        out_chosen_slot,
  output logic signed [15:0] out_quality,
  output logic              out_last
);

  // configuration registers
  logic [8:0]         alpha_r, gamma_r;
  logic [3:0]         home_r;
  logic signed [15:0] penalty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r   <= 9'd128;
      gamma_r   <= 9'd230;
      home_r    <= 4'd0;
      penalty_r <= -16'sd1280;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ALPHA:   alpha_r   <= cfg_data[8:0];
        CFG_GAMMA:   gamma_r   <= cfg_data[8:0];
        CFG_HOME:    home_r    <= cfg_data[3:0];
        CFG_PENALTY: penalty_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [ST_W-1:0] home_idx;
  assign home_idx = home_r[ST_W-1:0];

  // captured input transaction
  logic [1:0]         op_r;
  logic [3:0]         sidx_r, tst_r, tot_r;
  logic [2:0]         slot_r;
  logic signed [15:0] val_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_op;
      sidx_r <= in_state_index;
      slot_r <= in_action_slot;
      tst_r  <= in_target_state;
      tot_r  <= in_action_total;
      val_r  <= in_value;
    end
  end

  // walk and pending state
  logic [ST_W-1:0]  walk_r;
  logic [ENT_W-1:0] pend_r;
  logic             pvalid_r;
  logic [CNT_W-1:0] count_r [NUM_STATES];

  // stores
  logic             q_we;
  logic [ENT_W-1:0] q_waddr, rd_addr;
  logic [15:0]      q_wdata, q_rdata;
  logic [3:0]       t_rdata;

  // update arithmetic
  logic signed [15:0] reward;
  logic [8:0]         alpha_c, gamma_c;
  logic signed [25:0] gm_r;
  logic signed [26:0] inner;
  logic signed [36:0] prod_r;
  logic signed [37:0] rnd;
  logic signed [21:0] delta;
  logic signed [22:0] sum;
  logic signed [15:0] newq;

  // argmax scan
  logic [ST_W-1:0]   scan_st;
  logic [CNT_W-1:0]  scan_n;
  logic [CNT_W-1:0]  sidx_cnt_r;
  logic              acc_v_r;
  logic [SLOT_W-1:0] acc_slot_r;
  logic signed [15:0] best_r;
  logic [SLOT_W-1:0] best_slot_r;
  logic              best_any_r;

  logic [ST_W-1:0] tgt_r;
  logic signed [15:0] pq_r;

  assign scan_st = cmd.scan_tgt ? tgt_r : walk_r;
  assign scan_n  = count_r[scan_st];

  logic signed [15:0] best_nxt;
  logic [SLOT_W-1:0]  best_slot_nxt;
  logic               best_any_nxt;

  // read address: pending entry, chosen slot of the walk state, or scan slot
  always_comb begin
    if (cmd.rd_pend && !cmd.scan_acc) begin
      rd_addr = pend_r;
    end else if (cmd.rd_pend) begin
      rd_addr = {walk_r, best_slot_nxt};
    end else begin
      rd_addr = {scan_st, sidx_cnt_r[SLOT_W-1:0]};
    end
  end

  // compare previous read against running best
  always_comb begin
    best_nxt      = best_r;
    best_slot_nxt = best_slot_r;
    best_any_nxt  = best_any_r;
    if (acc_v_r && (!best_any_r || ($signed(q_rdata) > best_r))) begin
      best_nxt      = $signed(q_rdata);
      best_slot_nxt = acc_slot_r;
      best_any_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_v_r    <= 1'b0;
      best_any_r <= 1'b0;
      sidx_cnt_r <= '0;
    end else if (cmd.scan_init) begin
      acc_v_r    <= 1'b0;
      best_any_r <= 1'b0;
      sidx_cnt_r <= '0;
    end else begin
      acc_v_r <= cmd.scan_rd;
      if (acc_v_r) begin
        best_any_r <= best_any_nxt;
      end
      if (cmd.scan_rd) begin
        sidx_cnt_r <= sidx_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_slot_r <= sidx_cnt_r[SLOT_W-1:0];
    if (acc_v_r) begin
      best_r      <= best_nxt;
      best_slot_r <= best_slot_nxt;
    end
  end

  // table write on load or quality update
  always_comb begin
    q_we    = cmd.tbl_write || cmd.wr_q;
    q_waddr = cmd.wr_q ? pend_r : {sidx_r[ST_W-1:0], slot_r[SLOT_W-1:0]};
    q_wdata = cmd.wr_q ? newq : val_r;
  end

  qtgu_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_qram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(rd_addr), .rdata(q_rdata)
  );

  qtgu_ram #(.WIDTH(4), .DEPTH(ENTRIES)) u_tram (
    .clk(clk), .we(cmd.tbl_write), .waddr(q_waddr), .wdata(tst_r),
    .raddr(rd_addr), .rdata(t_rdata)
  );

  // action counts, cleared at reset
  logic [CNT_W-1:0] tot_sat;
  assign tot_sat = (tot_r > 4'(MAX_ACTIONS)) ? CNT_W'(MAX_ACTIONS) : tot_r[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STATES; i++) begin
        count_r[i] <= '0;
      end
    end else if (cmd.tbl_write) begin
      count_r[sidx_r[ST_W-1:0]] <= tot_sat;
    end
  end

  assign reward  = cmd.use_penalty ? penalty_r : val_r;
  assign alpha_c = alpha_r[8] ? 9'd256 : alpha_r;
  assign gamma_c = gamma_r[8] ? 9'd256 : gamma_r;
  assign inner   = (27'(reward) <<< 8) + 27'(gm_r) - (27'(pq_r) <<< 8);
  assign rnd     = 38'(prod_r) + 38'sd32768;
  assign delta   = rnd[37:16];
  assign sum     = 23'(pq_r) + 23'(delta);
  assign newq    = (sum > 23'sd32767) ? 16'sd32767 :
                   (sum < -23'sd32768) ? -16'sd32768 : sum[15:0];

  always_ff @(posedge clk) begin
    if (cmd.cap_pend) begin
      pq_r  <= $signed(q_rdata);
      tgt_r <= t_rdata[ST_W-1:0];
    end
    if (cmd.mul1) begin
      gm_r <= best_any_r ? ($signed({1'b0, gamma_c}) * best_r) : 26'sd0;
    end
    if (cmd.mul2) begin
      prod_r <= $signed({1'b0, alpha_c}) * inner;
    end
  end

  // walk and pending registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r   <= '0;
      pend_r   <= '0;
      pvalid_r <= 1'b0;
    end else begin
      if (cmd.go_home) begin
        walk_r   <= home_idx;
        pvalid_r <= 1'b0;
      end
      if (cmd.emit_choice) begin
        walk_r   <= t_rdata[ST_W-1:0];
        pend_r   <= {walk_r, best_slot_r};
        pvalid_r <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.emit_upd || cmd.emit_err_home || cmd.emit_err_cur ||
                    cmd.emit_choice;
    end
  end

  always_ff @(posedge clk) begin
    out_last <= cmd.last;
    if (cmd.emit_upd) begin
      out_kind        <= KIND_UPDATE;
      out_now_state   <= 4'(home_idx);
      out_chosen_slot <= 3'(pend_r[SLOT_W-1:0]);
      out_quality     <= newq;
    end else if (cmd.emit_err_home) begin
      out_kind        <= KIND_ERROR;
      out_now_state   <= 4'(home_idx);
      out_chosen_slot <= '0;
      out_quality     <= '0;
    end else if (cmd.emit_err_cur) begin
      out_kind        <= KIND_ERROR;
      out_now_state   <= 4'(walk_r);
      out_chosen_slot <= '0;
      out_quality     <= '0;
    end else if (cmd.emit_choice) begin
      out_kind        <= KIND_CHOSEN;
      out_now_state   <= t_rdata;
      out_chosen_slot <= 3'(best_slot_r);
      out_quality     <= best_r;
    end
  end

  // status
  assign sts.op         = op_r;
  assign sts.load_ok    = (32'(sidx_r) < NUM_STATES) && (32'(slot_r) < MAX_ACTIONS) &&
                          (32'(tst_r) < NUM_STATES);
  assign sts.away       = (walk_r != home_idx);
  assign sts.pend_valid = pvalid_r;
  assign sts.scan_done  = (sidx_cnt_r >= scan_n);
  assign sts.scan_empty = !best_any_r;

endmodule

/* rtl/core/q_table_greedy_update_unit.sv */
// order of work: a stop runs the pending update; a start runs the pending update, then a scan
// of up to 8 slots at one table read per cycle
// throughput: one transaction at a time; busy stays high until the last result
// results appear on out_strobe for one cycle each; the receiver cannot stall
// reset: rst_n synchronous; configuration, walk and output strobe registers take their defaults, action counts clear
module q_table_greedy_update_unit import qtgu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_op,
  input  logic [3:0]        in_state_index,
  input  logic [2:0]        in_action_slot,
  input  logic [3:0]        in_target_state,
  input  logic [3:0]        in_action_total,
  input  logic signed [15:0] in_value,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              out_strobe,
  output logic [1:0]        out_kind,
  output logic [3:0]        out_now_state,
  output logic [2:0]        out_chosen_slot,
  output logic signed [15:0] out_quality,
  output logic              out_last
);

  qtgu_cmd_t cmd;
  qtgu_sts_t sts;

  assign cfg_ready = 1'b1;

  qtgu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  qtgu_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_op(in_op), .in_state_index(in_state_index), .in_action_slot(in_action_slot),
    .in_target_state(in_target_state), .in_action_total(in_action_total),
    .in_value(in_value), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_strobe(out_strobe), .out_kind(out_kind),
    .out_now_state(out_now_state), .out_chosen_slot(out_chosen_slot),
    .out_quality(out_quality), .out_last(out_last)
  );

`ifndef SYNTHESIS
  // no result while idle for more than a cycle
  a_no_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !$past(busy)) |-> !out_strobe) else $error("result while idle");
  // a final result ends the transaction
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> !busy) else $error("busy after last result");
  // a final update result ends the transaction
  a_upd_home: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_kind == KIND_UPDATE) |-> out_last == 1'b0 || !busy)
    else $error("update result framing");
`endif

endmodule

/* tb/sv/tb_q_table_greedy_update_unit.sv */
module tb_q_table_greedy_update_unit;
  import qtgu_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int SETTLE = 40;

  typedef struct {
    logic [1:0]  op;
    logic [3:0]  st;
    logic [2:0]  slot;
    logic [3:0]  tgt;
    logic [3:0]  tot;
    logic [15:0] val;
  } command_t;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  now;
    logic [2:0]  slot;
    logic [15:0] q;
    logic        last;
  } outcome_t;

  logic clk, rst_n, start, busy;
  logic [1:0] in_op;
  logic [3:0] in_state_index, in_target_state, in_action_total;
  logic [2:0] in_action_slot;
  logic signed [15:0] in_value;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic out_strobe, out_last;
  logic [1:0] out_kind;
  logic [3:0] out_now_state;
  logic [2:0] out_chosen_slot;
  logic signed [15:0] out_quality;

  q_table_greedy_update_unit uut (.*);

  command_t cmd_fifo[$];
  outcome_t expected_outcomes[$];
  int err_count = 0;

  // predictor state
  logic [8:0]  alpha_r, gamma_r;
  logic [3:0]  home_r;
  logic signed [15:0] penalty_r;
  logic signed [15:0] q_mem[ENTRIES];
  logic [3:0]  tgt_mem[ENTRIES];
  logic [3:0]  cnt_mem[NUM_STATES];
  logic [3:0]  walk_r;
  logic [6:0]  pend_r;
  logic        pend_ok;

  // generator shadow of loaded slots
  bit written[ENTRIES];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    err_count++;
  endtask

  // greedy argmax over a state's actions
  function automatic bit best_action(input logic [3:0] s, output logic [2:0] bs,
                                     output logic signed [15:0] bq);
    int n;
    n = cnt_mem[s];
    bs = 0;
    bq = 0;
    if (n == 0) return 0;
    bq = q_mem[s * MAX_ACTIONS];
    for (int i = 1; i < n; i++) begin
      if (q_mem[s * MAX_ACTIONS + i] > bq) begin
        bq = q_mem[s * MAX_ACTIONS + i];
        bs = 3'(i);
      end
    end
    return 1;
  endfunction

  // quality update of the pending action, returns the update or error result
  function automatic outcome_t close_walk(input logic signed [15:0] reward);
    outcome_t o;
    logic [2:0] ds;
    logic signed [15:0] mq, q;
    longint a, g, inner, prod, nq;
    walk_r = home_r;
    o = '{KIND_ERROR, home_r, 3'd0, 16'd0, 1'b0};
    if (!pend_ok) return o;
    pend_ok = 0;
    q = q_mem[pend_r];
    if (!best_action(tgt_mem[pend_r], ds, mq)) mq = 0;
    a = (alpha_r > 256) ? 256 : alpha_r;
    g = (gamma_r > 256) ? 256 : gamma_r;
    inner = longint'(reward) * 256 + g * longint'(mq) - longint'(q) * 256;
    prod = a * inner;
    nq = longint'(q) + ((prod + 32768) >>> 16);
    if (nq > 32767) nq = 32767;
    if (nq < -32768) nq = -32768;
    q_mem[pend_r] = nq[15:0];
    o = '{KIND_UPDATE, home_r, pend_r[2:0], nq[15:0], 1'b0};
    return o;
  endfunction

  function automatic void predict(input command_t c);
    outcome_t o;
    logic [2:0] bs;
    logic signed [15:0] bq;
    int e;
    case (c.op)
      OP_LOAD: begin
        e = c.st * MAX_ACTIONS + c.slot;
        q_mem[e] = c.val;
        tgt_mem[e] = c.tgt;
        cnt_mem[c.st] = (c.tot > MAX_ACTIONS) ? 4'(MAX_ACTIONS) : c.tot;
      end
      OP_START: begin
        if (walk_r != home_r) expected_outcomes.push_back(close_walk(penalty_r));
        if (best_action(walk_r, bs, bq)) begin
          pend_r = {walk_r, bs};
          pend_ok = 1;
          walk_r = tgt_mem[pend_r];
          o = '{KIND_CHOSEN, walk_r, bs, bq, 1'b1};
        end else begin
          o = '{KIND_ERROR, walk_r, 3'd0, 16'd0, 1'b1};
        end
        expected_outcomes.push_back(o);
      end
      OP_STOP: begin
        o = close_walk(c.val);
        o.last = 1;
        expected_outcomes.push_back(o);
      end
      default: ;
    endcase
  endfunction

  // monitor: accepted transactions, config writes, results
  always @(posedge clk) begin
    outcome_t w;
    if (!rst_n) begin
      alpha_r = 128; gamma_r = 230; home_r = 0; penalty_r = -1280;
      walk_r = 0; pend_r = 0; pend_ok = 0;
      for (int i = 0; i < NUM_STATES; i++) cnt_mem[i] = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ALPHA:   alpha_r = cfg_data[8:0];
          CFG_GAMMA:   gamma_r = cfg_data[8:0];
          CFG_HOME:    home_r = cfg_data[3:0];
          CFG_PENALTY: penalty_r = cfg_data;
          default: ;
        endcase
      end
      if (out_strobe) begin
        if (expected_outcomes.size() == 0) begin
          report("unexpected result kind", 16'(out_kind), 16'd0);
        end else begin
          w = expected_outcomes.pop_front();
          if (out_kind !== w.kind) report("kind", 16'(out_kind), 16'(w.kind));
          if (out_now_state !== w.now)
            report("now_state", 16'(out_now_state), 16'(w.now));
          if (out_chosen_slot !== w.slot)
            report("chosen_slot", 16'(out_chosen_slot), 16'(w.slot));
          if (out_quality !== w.q) report("quality", out_quality, w.q);
          if (out_last !== w.last) report("last", 16'(out_last), 16'(w.last));
        end
      end
      if (start && !busy)
        predict('{in_op, in_state_index, in_action_slot, in_target_state,
                  in_action_total, in_value});
    end
  end

  // driver: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    command_t c;
    if (!rst_n) begin
      start <= 0;
    end else begin
      if (start && !busy) begin
        void'(cmd_fifo.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 30);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 0;
      end else if (cmd_fifo.size() > 0) begin
        c = cmd_fifo[0];
        start <= 1;
        in_op <= c.op;
        in_state_index <= c.st;
        in_action_slot <= c.slot;
        in_target_state <= c.tgt;
        in_action_total <= c.tot;
        in_value <= c.val;
      end else begin
        start <= 0;
      end
    end
  end

  // load whose count only covers slots already loaded
  task automatic add_load(input logic [3:0] s, input logic [2:0] a, input logic [3:0] t,
                          input int tot, input logic [15:0] v);
    int eff;
    written[s * MAX_ACTIONS + a] = 1;
    eff = (tot > MAX_ACTIONS) ? MAX_ACTIONS : tot;
    for (int i = 0; i < eff; i++)
      if (!written[s * MAX_ACTIONS + i]) begin
        eff = i;
        break;
      end
    if (!(tot > MAX_ACTIONS && eff == MAX_ACTIONS)) tot = eff;
    cmd_fifo.push_back('{OP_LOAD, s, a, t, tot[3:0], v});
  endtask

  task automatic add_cmd(input logic [1:0] op, input logic [15:0] v);
    cmd_fifo.push_back('{op, 4'($urandom), 3'($urandom), 4'($urandom), 4'($urandom), v});
  endtask

  task automatic drain();
    while (cmd_fifo.size() > 0 || expected_outcomes.size() > 0 || busy || start)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        add_load(4'($urandom), $urandom_range(0, 1) ? 3'($urandom_range(0, 3)) : 3'($urandom),
                 4'($urandom), $urandom_range(0, 15), rand_value());
      end else if (r < 65) add_cmd(OP_START, rand_value());
      else if (r < 95) add_cmd(OP_STOP, rand_value());
      else add_cmd(OP_NONE, rand_value());
    end
    drain();
  endtask

  initial begin
    logic [15:0] dq[8];
    rst_n = 0; start = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    in_op = 0; in_state_index = 0; in_action_slot = 0; in_target_state = 0;
    in_action_total = 0; in_value = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, ties, target without actions, count too large
    dq = '{16'h8000, 16'h7fff, 16'h7fff, 16'h0000, 16'hffff, 16'h0100, 16'h8001, 16'h7ffe};
    for (int i = 0; i < 8; i++)
      add_load(0, i, (i == 2) ? 4'd3 : (i == 1) ? 4'd1 : 4'd15, (i == 7) ? 15 : i + 1, dq[i]);
    add_load(1, 0, 0, 1, 16'h0064);
    add_load(15, 0, 3, 1, 16'hff00);
    add_cmd(OP_START, 0);
    add_cmd(OP_STOP, 16'h7fff);
    add_cmd(OP_STOP, 16'h8000);
    add_cmd(OP_START, 0);
    add_cmd(OP_START, 0);
    add_cmd(OP_START, 0);
    add_cmd(OP_NONE, 16'hffff);
    add_cmd(OP_STOP, 16'h0000);
    drain();

    // state without actions as home
    write_reg(CFG_HOME, 16'd3);
    add_cmd(OP_START, 0);
    add_cmd(OP_STOP, 16'h1234);
    drain();

    random_phase(180);
    write_reg(CFG_ALPHA, 16'd256);
    write_reg(CFG_GAMMA, 16'd0);
    write_reg(CFG_HOME, 16'hfff0);
    write_reg(CFG_PENALTY, 16'h8000);
    random_phase(180);
    write_reg(CFG_ALPHA, 16'hffff);
    write_reg(CFG_GAMMA, 16'h01ff);
    write_reg(CFG_HOME, 16'd15);
    write_reg(CFG_PENALTY, 16'h7fff);
    random_phase(180);
    write_reg(CFG_ALPHA, 16'd0);
    write_reg(CFG_GAMMA, 16'd256);
    write_reg(CFG_HOME, 16'd1);
    write_reg(CFG_PENALTY, 16'h0000);
    random_phase(180);
    write_reg(CFG_ALPHA, 16'($urandom_range(0, 511)));
    write_reg(CFG_GAMMA, 16'($urandom_range(0, 511)));
    write_reg(CFG_HOME, 16'($urandom_range(0, 1)));
    write_reg(CFG_PENALTY, 16'($urandom));
    random_phase(190);

    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
